FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

FILE: src/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants of the serial frame receiver queue.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int unsigned DEF_MAX_DATA_BYTES = 64;
  localparam int unsigned DEF_QUEUE_SLOTS    = 8;
  localparam int unsigned CMDQ_DEPTH         = 4;

  localparam int unsigned SLOT_FIELD_W = 6;
  localparam int unsigned WAIT_W       = 6;
  localparam int unsigned ERR_W        = 16;

  localparam logic [7:0]       PREAMBLE_BYTE = 8'hAA;
  localparam logic [7:0]       START_BYTE    = 8'hAB;
  localparam logic [2:0]       PREAMBLE_LEN  = 3'd7;
  localparam logic [ERR_W-1:0] ERR_MAX       = 16'hFFFF;

  // Result kinds.
  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_BYTE   = 2'd1;
  localparam logic [1:0] KIND_EMPTY  = 2'd2;

  // Frame events.
  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_ACCEPTED = 3'd1;
  localparam logic [2:0] EV_CSUM_BAD = 3'd2;
  localparam logic [2:0] EV_SYNC_BAD = 3'd3;
  localparam logic [2:0] EV_TOO_LONG = 3'd4;
  localparam logic [2:0] EV_Q_FULL   = 3'd5;

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_START = 3'd1,
    PH_LEN   = 3'd2,
    PH_DATA  = 3'd3,
    PH_CSUM  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_LEN   = 2'd1,
    BK_BYTES = 2'd2
  } back_state_t;

  // One entry of the command queue between the parser and the read-out side.
  typedef struct packed {
    logic                    rd;          // message read-out, else one status result
    logic [1:0]              kind;
    logic [2:0]              frame_event;
    logic [ERR_W-1:0]        error_count;
    logic [WAIT_W-1:0]       waiting;
    logic [SLOT_FIELD_W-1:0] slot;
  } cmd_t;

endpackage

FILE: src/serial_frame_receiver_queue_top.sv
// ----------------------------------------------------------------------------
// serial_frame_receiver_queue_top
// Serial frame receiver with a circular message queue and read-out port.
// ----------------------------------------------------------------------------
// Each request is either one received serial byte or a read of the oldest
// queued message. A received byte is parsed in the cycle it is accepted and
// produces exactly one status result, so bytes stream in at one per cycle.
// A read request is accepted in the same way; the read-out sequencer first
// fetches the message length and the first byte, then gives the results at
// one byte per cycle while the output is not stalled, and the input side
// keeps taking bytes meanwhile. The rate is set by the single read port of
// the message store. The parser holds off a data or checksum byte only while
// the slot it would write is still being read out, and the input side stalls
// when the four-entry command queue between the two sides is full. The
// stores need no clearing after reset.
// ----------------------------------------------------------------------------
module serial_frame_receiver_queue_top #(
  parameter int unsigned MAX_DATA_BYTES = sfr_pkg::DEF_MAX_DATA_BYTES,
  parameter int unsigned QUEUE_SLOTS    = sfr_pkg::DEF_QUEUE_SLOTS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       operation,
  input  logic [7:0]                 rx_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 kind,
  output logic [7:0]                 data_byte,
  output logic                       last,
  output logic [2:0]                 frame_event,
  output logic [sfr_pkg::ERR_W-1:0]  error_count,
  output logic [sfr_pkg::WAIT_W-1:0] messages_waiting
);
  import sfr_pkg::*;

  localparam int unsigned SLOT_W = $clog2(QUEUE_SLOTS);
  localparam int unsigned CNT_W  = $clog2(MAX_DATA_BYTES + 1);
  localparam int unsigned ADDR_W = $clog2(QUEUE_SLOTS * MAX_DATA_BYTES);

  // Command queue between parser and read-out side.
  logic cq_push, cq_full, cq_pop, cq_empty;
  cmd_t cq_data, cq_head;
  logic rd_done;

  // Message store: one region of MAX_DATA_BYTES bytes per queue slot.
  logic              store_we, store_re;
  logic [ADDR_W-1:0] store_waddr, store_raddr;
  logic [7:0]        store_wdata, store_rdata;

  // Length of the message held in each slot.
  logic              len_we, len_re;
  logic [SLOT_W-1:0] len_waddr, len_raddr;
  logic [CNT_W-1:0]  len_wdata, len_rdata;

  sfr_front #(
    .MAX_DATA_BYTES(MAX_DATA_BYTES),
    .QUEUE_SLOTS   (QUEUE_SLOTS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .rx_byte     (rx_byte),
    .cq_full     (cq_full),
    .cq_push     (cq_push),
    .cq_data     (cq_data),
    .rd_done     (rd_done),
    .store_we    (store_we),
    .store_waddr (store_waddr),
    .store_wdata (store_wdata),
    .len_we      (len_we),
    .len_waddr   (len_waddr),
    .len_wdata   (len_wdata)
  );

  sfr_cmdq #(
    .DEPTH(CMDQ_DEPTH)
  ) u_cmdq (
    .clk       (clk),
    .rst       (rst),
    .push      (cq_push),
    .push_data (cq_data),
    .full      (cq_full),
    .pop       (cq_pop),
    .head      (cq_head),
    .empty     (cq_empty)
  );

  sfr_ram #(
    .WIDTH(8),
    .DEPTH(QUEUE_SLOTS * MAX_DATA_BYTES)
  ) u_store (
    .clk     (clk),
    .wr_en   (store_we),
    .wr_addr (store_waddr),
    .wr_data (store_wdata),
    .rd_en   (store_re),
    .rd_addr (store_raddr),
    .rd_data (store_rdata)
  );

  sfr_ram #(
    .WIDTH(CNT_W),
    .DEPTH(QUEUE_SLOTS)
  ) u_lengths (
    .clk     (clk),
    .wr_en   (len_we),
    .wr_addr (len_waddr),
    .wr_data (len_wdata),
    .rd_en   (len_re),
    .rd_addr (len_raddr),
    .rd_data (len_rdata)
  );

  sfr_back #(
    .MAX_DATA_BYTES(MAX_DATA_BYTES),
    .QUEUE_SLOTS   (QUEUE_SLOTS)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .cq_empty         (cq_empty),
    .cq_head          (cq_head),
    .cq_pop           (cq_pop),
    .rd_done          (rd_done),
    .len_re           (len_re),
    .len_raddr        (len_raddr),
    .len_rdata        (len_rdata),
    .store_re         (store_re),
    .store_raddr      (store_raddr),
    .store_rdata      (store_rdata),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .kind             (kind),
    .data_byte        (data_byte),
    .last             (last),
    .frame_event      (frame_event),
    .error_count      (error_count),
    .messages_waiting (messages_waiting)
  );

endmodule

FILE: src/sfr_ram.sv
// ----------------------------------------------------------------------------
// sfr_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module sfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: src/sfr_cmdq.sv
// ----------------------------------------------------------------------------
// sfr_cmdq
// Short command FIFO that decouples the frame parser from the read-out side.
// ----------------------------------------------------------------------------
module sfr_cmdq #(
  parameter int unsigned DEPTH = sfr_pkg::CMDQ_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sfr_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output sfr_pkg::cmd_t head,
  output logic          empty
);
  import sfr_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: src/sfr_front.sv
// ----------------------------------------------------------------------------
// sfr_front
// Frame parser: takes requests, tracks the frame, writes the message store
// and posts one command per request to the read-out side.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sfr_front #(
  parameter int unsigned MAX_DATA_BYTES = sfr_pkg::DEF_MAX_DATA_BYTES,
  parameter int unsigned QUEUE_SLOTS    = sfr_pkg::DEF_QUEUE_SLOTS
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              in_valid,
  output logic                                              in_ready,
  input  logic                                              operation,
  input  logic [7:0]                                        rx_byte,
  input  logic                                              cq_full,
  output logic                                              cq_push,
  output sfr_pkg::cmd_t                                     cq_data,
  input  logic                                              rd_done,
  output logic                                              store_we,
  output logic [$clog2(QUEUE_SLOTS*MAX_DATA_BYTES)-1:0]     store_waddr,
  output logic [7:0]                                        store_wdata,
  output logic                                              len_we,
  output logic [$clog2(QUEUE_SLOTS)-1:0]                    len_waddr,
  output logic [$clog2(MAX_DATA_BYTES+1)-1:0]               len_wdata
);
  import sfr_pkg::*;

  localparam int unsigned SLOT_W = $clog2(QUEUE_SLOTS);
  localparam int unsigned CNT_W  = $clog2(MAX_DATA_BYTES + 1);
  localparam int unsigned ADDR_W = $clog2(QUEUE_SLOTS * MAX_DATA_BYTES);
  localparam int unsigned K_W    = $clog2(QUEUE_SLOTS + 1);

  phase_t            phase, phase_next;
  logic [2:0]        preamble_run, preamble_run_next;
  logic              field_byte_index, field_byte_index_next;
  logic [15:0]       frame_length, frame_length_next;
  logic [CNT_W-1:0]  data_byte_count, data_byte_count_next;
  logic [15:0]       running_sum, running_sum_next;
  logic [7:0]        sum_high_byte, sum_high_byte_next;
  logic [SLOT_W-1:0] read_slot, read_slot_next;
  logic [SLOT_W-1:0] write_slot, write_slot_next;
  logic [ERR_W-1:0]  bad_count, bad_count_next;
  logic [K_W-1:0]    pending_reads;

  logic              accept;
  logic              bad_inc;
  logic              rd_issue;
  logic [2:0]        ev;
  logic [SLOT_W-1:0] write_slot_inc;
  logic [SLOT_W-1:0] read_slot_inc;
  logic [15:0]       len_assembled;
  logic [CNT_W-1:0]  count_inc;
  logic [SLOT_W:0]   gap;
  logic [SLOT_W:0]   wait_sum;
  logic              hazard;

  assign write_slot_inc = (write_slot == SLOT_W'(QUEUE_SLOTS - 1)) ? '0 : write_slot + 1'b1;
  assign read_slot_inc  = (read_slot == SLOT_W'(QUEUE_SLOTS - 1)) ? '0 : read_slot + 1'b1;
  assign len_assembled  = {frame_length[15:8], rx_byte};
  assign count_inc      = data_byte_count + 1'b1;

  // Slots freed by reads but still being read out sit just below read_slot.
  // A byte that writes the store must wait while write_slot is one of them.
  always_comb begin
    gap = {1'b0, read_slot} + (SLOT_W + 1)'(QUEUE_SLOTS - 1) - {1'b0, write_slot};
    if (gap >= (SLOT_W + 1)'(QUEUE_SLOTS)) begin
      gap = gap - (SLOT_W + 1)'(QUEUE_SLOTS);
    end
    hazard = (gap < (SLOT_W + 1)'(pending_reads));
  end

  assign in_ready = !cq_full &&
                    !(hazard && !operation && (phase == PH_DATA || phase == PH_CSUM));
  assign accept   = in_valid && in_ready;

  always_comb begin
    phase_next            = phase;
    preamble_run_next     = preamble_run;
    field_byte_index_next = field_byte_index;
    frame_length_next     = frame_length;
    data_byte_count_next  = data_byte_count;
    running_sum_next      = running_sum;
    sum_high_byte_next    = sum_high_byte;
    read_slot_next        = read_slot;
    write_slot_next       = write_slot;
    ev                    = EV_NONE;
    bad_inc               = 1'b0;
    rd_issue              = 1'b0;
    store_we              = 1'b0;
    len_we                = 1'b0;

    if (accept && !operation) begin
      case (phase)
        PH_START: begin
          if (rx_byte == START_BYTE) begin
            phase_next            = PH_LEN;
            field_byte_index_next = 1'b0;
            frame_length_next     = '0;
          end else begin
            phase_next        = PH_HUNT;
            preamble_run_next = '0;
            bad_inc           = 1'b1;
            ev                = EV_SYNC_BAD;
          end
        end
        PH_LEN: begin
          if (!field_byte_index) begin
            frame_length_next     = {rx_byte, 8'h00};
            field_byte_index_next = 1'b1;
          end else begin
            frame_length_next     = len_assembled;
            data_byte_count_next  = '0;
            running_sum_next      = '0;
            field_byte_index_next = 1'b0;
            phase_next            = (len_assembled == '0) ? PH_CSUM : PH_DATA;
          end
        end
        PH_DATA: begin
          if (frame_length > 16'(MAX_DATA_BYTES)) begin
            phase_next        = PH_HUNT;
            preamble_run_next = '0;
            bad_inc           = 1'b1;
            ev                = EV_TOO_LONG;
          end else begin
            store_we             = 1'b1;
            running_sum_next     = running_sum + 16'(rx_byte);
            data_byte_count_next = count_inc;
            if (16'(count_inc) >= frame_length) begin
              phase_next            = PH_CSUM;
              field_byte_index_next = 1'b0;
            end
          end
        end
        PH_CSUM: begin
          if (!field_byte_index) begin
            sum_high_byte_next    = rx_byte;
            field_byte_index_next = 1'b1;
          end else begin
            field_byte_index_next = 1'b0;
            phase_next            = PH_HUNT;
            preamble_run_next     = '0;
            if ({sum_high_byte, rx_byte} == running_sum) begin
              if (write_slot_inc == read_slot) begin
                ev = EV_Q_FULL;
              end else begin
                len_we          = 1'b1;
                write_slot_next = write_slot_inc;
                ev              = EV_ACCEPTED;
              end
            end else begin
              bad_inc = 1'b1;
              ev      = EV_CSUM_BAD;
            end
          end
        end
        PH_HUNT: begin
          if (rx_byte == PREAMBLE_BYTE) begin
            preamble_run_next = preamble_run + 1'b1;
          end else begin
            preamble_run_next = '0;
            bad_inc           = 1'b1;
            ev                = EV_SYNC_BAD;
          end
          if (preamble_run_next >= PREAMBLE_LEN) begin
            phase_next = PH_START;
          end
        end
        default: begin
          phase_next = PH_HUNT;
        end
      endcase
    end else if (accept && operation && (read_slot != write_slot)) begin
      rd_issue       = 1'b1;
      read_slot_next = read_slot_inc;
    end

    bad_count_next = (bad_inc && bad_count != ERR_MAX) ? bad_count + 1'b1 : bad_count;

    wait_sum = {1'b0, write_slot_next} + (SLOT_W + 1)'(QUEUE_SLOTS) - {1'b0, read_slot_next};
    if (wait_sum >= (SLOT_W + 1)'(QUEUE_SLOTS)) begin
      wait_sum = wait_sum - (SLOT_W + 1)'(QUEUE_SLOTS);
    end
  end

  assign store_waddr = ADDR_W'(write_slot) * ADDR_W'(MAX_DATA_BYTES) + ADDR_W'(data_byte_count);
  assign store_wdata = rx_byte;
  assign len_waddr   = write_slot;
  assign len_wdata   = frame_length[CNT_W-1:0];

  always_comb begin
    cq_push             = accept;
    cq_data.rd          = rd_issue;
    cq_data.kind        = operation ? KIND_EMPTY : KIND_STATUS;
    cq_data.frame_event = ev;
    cq_data.error_count = bad_count_next;
    cq_data.waiting     = WAIT_W'(wait_sum);
    cq_data.slot        = SLOT_FIELD_W'(read_slot);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HUNT;
      preamble_run     <= '0;
      field_byte_index <= 1'b0;
      frame_length     <= '0;
      data_byte_count  <= '0;
      running_sum      <= '0;
      sum_high_byte    <= '0;
      read_slot        <= '0;
      write_slot       <= '0;
      bad_count        <= '0;
      pending_reads    <= '0;
    end else begin
      phase            <= phase_next;
      preamble_run     <= preamble_run_next;
      field_byte_index <= field_byte_index_next;
      frame_length     <= frame_length_next;
      data_byte_count  <= data_byte_count_next;
      running_sum      <= running_sum_next;
      sum_high_byte    <= sum_high_byte_next;
      read_slot        <= read_slot_next;
      write_slot       <= write_slot_next;
      bad_count        <= bad_count_next;
      if (rd_issue && !rd_done) begin
        pending_reads <= pending_reads + 1'b1;
      end else if (rd_done && !rd_issue) begin
        pending_reads <= pending_reads - 1'b1;
      end
    end
  end

  `ASSERT_IMPLIES(a_err_monotonic, !$past(rst), bad_count >= $past(bad_count), "error count went down")
  `ASSERT_ALWAYS(a_pending_bound, pending_reads <= K_W'(QUEUE_SLOTS), "too many reads in flight")
  `ASSERT_IMPLIES(a_no_store_overwrite, store_we, !hazard, "store write into a slot being read")

endmodule

FILE: src/sfr_back.sv
// ----------------------------------------------------------------------------
// sfr_back
// Read-out sequencer: turns queued commands into results, fetching message
// length and bytes from the stores, into a registered output stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sfr_back #(
  parameter int unsigned MAX_DATA_BYTES = sfr_pkg::DEF_MAX_DATA_BYTES,
  parameter int unsigned QUEUE_SLOTS    = sfr_pkg::DEF_QUEUE_SLOTS
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          cq_empty,
  input  sfr_pkg::cmd_t                                 cq_head,
  output logic                                          cq_pop,
  output logic                                          rd_done,
  output logic                                          len_re,
  output logic [$clog2(QUEUE_SLOTS)-1:0]                len_raddr,
  input  logic [$clog2(MAX_DATA_BYTES+1)-1:0]           len_rdata,
  output logic                                          store_re,
  output logic [$clog2(QUEUE_SLOTS*MAX_DATA_BYTES)-1:0] store_raddr,
  input  logic [7:0]                                    store_rdata,
  output logic                                          out_valid,
  input  logic                                          out_ready,
  output logic [1:0]                                    kind,
  output logic [7:0]                                    data_byte,
  output logic                                          last,
  output logic [2:0]                                    frame_event,
  output logic [sfr_pkg::ERR_W-1:0]                     error_count,
  output logic [sfr_pkg::WAIT_W-1:0]                    messages_waiting
);
  import sfr_pkg::*;

  localparam int unsigned SLOT_W = $clog2(QUEUE_SLOTS);
  localparam int unsigned CNT_W  = $clog2(MAX_DATA_BYTES + 1);
  localparam int unsigned ADDR_W = $clog2(QUEUE_SLOTS * MAX_DATA_BYTES);

  back_state_t       state, state_next;
  logic [SLOT_W-1:0] cur_slot, cur_slot_next;
  logic [CNT_W-1:0]  cur_len, cur_len_next;
  logic [CNT_W-1:0]  idx, idx_next;
  logic [ERR_W-1:0]  cur_err, cur_err_next;
  logic [WAIT_W-1:0] cur_wait, cur_wait_next;

  logic              out_free;
  logic              out_load;
  logic [1:0]        kind_next;
  logic [7:0]        data_byte_next;
  logic              last_next;
  logic [2:0]        frame_event_next;
  logic [ERR_W-1:0]  error_count_next;
  logic [WAIT_W-1:0] messages_waiting_next;
  logic [CNT_W-1:0]  fetch_idx;

  assign out_free    = !out_valid || out_ready;
  assign len_raddr   = cq_head.slot[SLOT_W-1:0];
  assign store_raddr = ADDR_W'(cur_slot) * ADDR_W'(MAX_DATA_BYTES) + ADDR_W'(fetch_idx);

  always_comb begin
    state_next            = state;
    cur_slot_next         = cur_slot;
    cur_len_next          = cur_len;
    idx_next              = idx;
    cur_err_next          = cur_err;
    cur_wait_next         = cur_wait;
    cq_pop                = 1'b0;
    rd_done               = 1'b0;
    len_re                = 1'b0;
    store_re              = 1'b0;
    fetch_idx             = idx + 1'b1;
    out_load              = 1'b0;
    kind_next             = KIND_STATUS;
    data_byte_next        = '0;
    last_next             = 1'b1;
    frame_event_next      = EV_NONE;
    error_count_next      = cur_err;
    messages_waiting_next = cur_wait;

    case (state)
      BK_IDLE: begin
        if (!cq_empty) begin
          if (cq_head.rd) begin
            cq_pop        = 1'b1;
            len_re        = 1'b1;
            cur_slot_next = cq_head.slot[SLOT_W-1:0];
            cur_err_next  = cq_head.error_count;
            cur_wait_next = cq_head.waiting;
            state_next    = BK_LEN;
          end else if (out_free) begin
            cq_pop                = 1'b1;
            out_load              = 1'b1;
            kind_next             = cq_head.kind;
            frame_event_next      = cq_head.frame_event;
            error_count_next      = cq_head.error_count;
            messages_waiting_next = cq_head.waiting;
          end
        end
      end
      BK_LEN: begin
        if (len_rdata == '0) begin
          if (out_free) begin
            out_load   = 1'b1;
            kind_next  = KIND_EMPTY;
            rd_done    = 1'b1;
            state_next = BK_IDLE;
          end
        end else begin
          fetch_idx    = '0;
          store_re     = 1'b1;
          cur_len_next = len_rdata;
          idx_next     = '0;
          state_next   = BK_BYTES;
        end
      end
      BK_BYTES: begin
        if (out_free) begin
          out_load       = 1'b1;
          kind_next      = KIND_BYTE;
          data_byte_next = store_rdata;
          last_next      = (idx == cur_len - 1'b1);
          if (last_next) begin
            rd_done    = 1'b1;
            state_next = BK_IDLE;
          end else begin
            store_re = 1'b1;
            idx_next = idx + 1'b1;
          end
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_slot <= cur_slot_next;
    cur_len  <= cur_len_next;
    idx      <= idx_next;
    cur_err  <= cur_err_next;
    cur_wait <= cur_wait_next;
    if (out_load) begin
      kind             <= kind_next;
      data_byte        <= data_byte_next;
      last             <= last_next;
      frame_event      <= frame_event_next;
      error_count      <= error_count_next;
      messages_waiting <= messages_waiting_next;
    end
  end

  `ASSERT_IMPLIES(a_bytes_have_length, state == BK_BYTES, cur_len != '0 && idx < cur_len, "byte index outside message")

endmodule

FILE: verif/sfr_tb_pkg.sv
// ----------------------------------------------------------------------------
// sfr_tb_pkg
// Request codes and payload types shared by the frame receiver testbench files.
// ----------------------------------------------------------------------------
package sfr_tb_pkg;

  // Request operation codes.
  localparam logic OP_RX_BYTE = 1'b0;
  localparam logic OP_READ    = 1'b1;

  typedef logic [7:0] byte_q_t [$];

endpackage

FILE: verif/sfr_result_checker.sv
// ----------------------------------------------------------------------------
// sfr_result_checker
// Watches both channels of the frame receiver, keeps its own copy of the
// parser and message queue, and compares every result with the prediction.
// ----------------------------------------------------------------------------
module sfr_result_checker
  import sfr_pkg::*;
  import sfr_tb_pkg::*;
#(
  parameter int unsigned MAX_DATA_BYTES = DEF_MAX_DATA_BYTES,
  parameter int unsigned QUEUE_SLOTS    = DEF_QUEUE_SLOTS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic              operation,
  input  logic [7:0]        rx_byte,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [1:0]        kind,
  input  logic [7:0]        data_byte,
  input  logic              last,
  input  logic [2:0]        frame_event,
  input  logic [ERR_W-1:0]  error_count,
  input  logic [WAIT_W-1:0] messages_waiting,
  output int                fail_count,
  output int                results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STORE_BYTES = QUEUE_SLOTS * MAX_DATA_BYTES;
  localparam int unsigned REPORT_CAP  = 200;

  typedef struct packed {
    logic [1:0]        kind;
    logic [7:0]        data;
    logic              last;
    logic [2:0]        ev;
    logic [ERR_W-1:0]  errs;
    logic [WAIT_W-1:0] waiting;
  } rx_result_t;

  rx_result_t due_q [$];

  // Receiver state.
  phase_t      parse_phase;
  int          aa_run;
  logic        second_field_byte;
  logic [15:0] frame_len;
  int          data_cnt;
  logic [15:0] data_sum;
  logic [7:0]  csum_hi;
  logic [7:0]  msg_mem [STORE_BYTES];
  int          msg_len [QUEUE_SLOTS];
  int          head_slot;
  int          tail_slot;
  int          err_total;

  function automatic int queued();
    return (tail_slot + QUEUE_SLOTS - head_slot) % QUEUE_SLOTS;
  endfunction

  task automatic add_result(input logic [1:0] k, input logic [7:0] d, input logic l,
                            input logic [2:0] ev);
    rx_result_t r;
    r.kind    = k;
    r.data    = d;
    r.last    = l;
    r.ev      = ev;
    r.errs    = err_total[ERR_W-1:0];
    r.waiting = WAIT_W'(queued());
    due_q.push_back(r);
  endtask

  task automatic note_error();
    if (err_total < ERR_MAX) err_total++;
  endtask

  task automatic back_to_hunt();
    parse_phase = PH_HUNT;
    aa_run      = 0;
  endtask

  // Advances the frame parser by one received byte and returns the frame event.
  task automatic rx_parse(input logic [7:0] b, output logic [2:0] ev);
    logic [15:0] got;
    ev = EV_NONE;
    case (parse_phase)
      PH_START: begin
        if (b == START_BYTE) begin
          parse_phase       = PH_LEN;
          second_field_byte = 1'b0;
          frame_len         = '0;
        end else begin
          back_to_hunt();
          note_error();
          ev = EV_SYNC_BAD;
        end
      end
      PH_LEN: begin
        if (!second_field_byte) begin
          frame_len         = {b, 8'h00};
          second_field_byte = 1'b1;
        end else begin
          frame_len         = {frame_len[15:8], b};
          data_cnt          = 0;
          data_sum          = '0;
          second_field_byte = 1'b0;
          parse_phase       = (frame_len == 0) ? PH_CSUM : PH_DATA;
        end
      end
      PH_DATA: begin
        if (frame_len > MAX_DATA_BYTES) begin
          back_to_hunt();
          note_error();
          ev = EV_TOO_LONG;
        end else begin
          msg_mem[tail_slot * MAX_DATA_BYTES + data_cnt] = b;
          data_sum = data_sum + b;
          data_cnt++;
          if (data_cnt >= frame_len) begin
            parse_phase       = PH_CSUM;
            second_field_byte = 1'b0;
          end
        end
      end
      PH_CSUM: begin
        if (!second_field_byte) begin
          csum_hi           = b;
          second_field_byte = 1'b1;
        end else begin
          got               = {csum_hi, b};
          second_field_byte = 1'b0;
          if (got == data_sum) begin
            if ((tail_slot + 1) % QUEUE_SLOTS == head_slot) begin
              ev = EV_Q_FULL;
            end else begin
              msg_len[tail_slot] = frame_len;
              tail_slot          = (tail_slot + 1) % QUEUE_SLOTS;
              ev                 = EV_ACCEPTED;
            end
          end else begin
            note_error();
            ev = EV_CSUM_BAD;
          end
          back_to_hunt();
        end
      end
      default: begin
        parse_phase = PH_HUNT;
        if (b == PREAMBLE_BYTE) begin
          aa_run++;
        end else begin
          note_error();
          aa_run = 0;
          ev     = EV_SYNC_BAD;
        end
        if (aa_run >= PREAMBLE_LEN) parse_phase = PH_START;
      end
    endcase
  endtask

  task automatic serve_request(input logic op, input logic [7:0] b);
    logic [2:0] ev;
    int         n;
    int         base;
    if (op == OP_RX_BYTE) begin
      rx_parse(b, ev);
      add_result(KIND_STATUS, 8'h00, 1'b1, ev);
    end else if (head_slot == tail_slot) begin
      add_result(KIND_EMPTY, 8'h00, 1'b1, EV_NONE);
    end else begin
      n = msg_len[head_slot];
      if (n > MAX_DATA_BYTES) n = MAX_DATA_BYTES;
      base      = head_slot * MAX_DATA_BYTES;
      head_slot = (head_slot + 1) % QUEUE_SLOTS;
      if (n == 0) begin
        add_result(KIND_EMPTY, 8'h00, 1'b1, EV_NONE);
      end else begin
        for (int i = 0; i < n; i++)
          add_result(KIND_BYTE, msg_mem[base + i], (i == n - 1), EV_NONE);
      end
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      if (fail_count < REPORT_CAP)
        $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      back_to_hunt();
      second_field_byte = 1'b0;
      frame_len         = '0;
      data_cnt          = 0;
      data_sum          = '0;
      csum_hi           = '0;
      head_slot         = 0;
      tail_slot         = 0;
      err_total         = 0;
      fail_count        = 0;
      due_q.delete();
    end else begin
      if (in_valid && in_ready) serve_request(operation, rx_byte);
      if (out_valid === 1'b1 && out_ready) begin
        if (due_q.size() == 0) begin
          if (fail_count < REPORT_CAP)
            $error("result with nothing pending: kind 0x%0h, data_byte 0x%0h", kind, data_byte);
          fail_count++;
        end else begin
          check_field("kind", 16'(due_q[0].kind), 16'(kind));
          check_field("data_byte", 16'(due_q[0].data), 16'(data_byte));
          check_field("last", 16'(due_q[0].last), 16'(last));
          check_field("frame_event", 16'(due_q[0].ev), 16'(frame_event));
          check_field("error_count", 16'(due_q[0].errs), 16'(error_count));
          check_field("messages_waiting", 16'(due_q[0].waiting), 16'(messages_waiting));
          void'(due_q.pop_front());
        end
      end
    end
    results_due = due_q.size();
  end

endmodule

FILE: verif/serial_frame_receiver_queue_top_tb.sv
// ----------------------------------------------------------------------------
// serial_frame_receiver_queue_top_tb
// Drives serial bytes and queue reads into the frame receiver and gives the
// verdict; a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
// The run opens with a directed part: bad bytes while hunting, an empty read,
// a zero-length frame and its read-out, an extra 0xAA where the start byte
// belongs, an oversize length, a bad checksum and a queue that overflows,
// led by a full 64-byte frame. Random traffic follows in four flow-control
// phases, mostly well-formed frames with random contents and lengths mixed
// with reads, broken preambles, bad start bytes, oversize lengths, bad
// checksums and plain noise.
// ----------------------------------------------------------------------------
module serial_frame_receiver_queue_top_tb;
  import sfr_pkg::*;
  import sfr_tb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int END_TAIL    = 20;
  localparam int PHASE_ITEMS = 10;

  logic              clk;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  logic              operation = OP_RX_BYTE;
  logic [7:0]        rx_byte   = 8'h00;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        kind;
  logic [7:0]        data_byte;
  logic              last;
  logic [2:0]        frame_event;
  logic [ERR_W-1:0]  error_count;
  logic [WAIT_W-1:0] messages_waiting;

  int fail_count;
  int results_due;

  // Percent of cycles in which the sender holds back or the receiver stalls.
  int idle_pct  = 0;
  int stall_pct = 0;

  int cycle_count   = 0;
  int requests_sent = 0;
  int frames_sent   = 0;
  int reads_sent    = 0;

  serial_frame_receiver_queue_top i_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .operation        (operation),
    .rx_byte          (rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .kind             (kind),
    .data_byte        (data_byte),
    .last             (last),
    .frame_event      (frame_event),
    .error_count      (error_count),
    .messages_waiting (messages_waiting)
  );

  sfr_result_checker #(
    .MAX_DATA_BYTES (DEF_MAX_DATA_BYTES),
    .QUEUE_SLOTS    (DEF_QUEUE_SLOTS)
  ) i_checker (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .operation        (operation),
    .rx_byte          (rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .kind             (kind),
    .data_byte        (data_byte),
    .last             (last),
    .frame_event      (frame_event),
    .error_count      (error_count),
    .messages_waiting (messages_waiting),
    .fail_count       (fail_count),
    .results_due      (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: a hung handshake or a result that never arrives ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // The result side stalls at random; its ready changes only on falling edges.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Presents one request at a falling edge, after an optional random gap, and
  // returns on the falling edge after it was taken. Valid stays high with a
  // steady payload until the block accepts it. Ready is looked at as the
  // clock rises, before the block's registers move.
  task automatic send_request(input logic op, input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    rx_byte   <= b;
    @(posedge clk iff in_ready);
    @(negedge clk);
    requests_sent++;
    if (op == OP_READ) reads_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_request(OP_RX_BYTE, b);
  endtask

  // Any byte but the preamble byte, so that it always breaks a preamble.
  function automatic logic [7:0] non_preamble();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if (b == PREAMBLE_BYTE) b = ~b;
    return b;
  endfunction

  function automatic byte_q_t random_payload(input int n);
    byte_q_t q;
    repeat (n) q.push_back(8'($urandom_range(255)));
    return q;
  endfunction

  // Mostly short frames, so that many complete frames fit in the run; now and
  // then a long one or one at the full 64 bytes.
  function automatic int pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 0;
    if (r < 90) return $urandom_range(1, 6);
    if (r < 97) return $urandom_range(7, DEF_MAX_DATA_BYTES - 1);
    return DEF_MAX_DATA_BYTES;
  endfunction

  // A whole frame; a nonzero mask spoils the checksum by flipping its bits.
  task automatic send_frame(input byte_q_t payload, input logic [15:0] csum_mask);
    logic [15:0] sum;
    logic [15:0] len;
    sum = '0;
    foreach (payload[i]) sum = sum + payload[i];
    len = 16'(payload.size());
    sum = sum ^ csum_mask;
    repeat (PREAMBLE_LEN) send_byte(PREAMBLE_BYTE);
    send_byte(START_BYTE);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    foreach (payload[i]) send_byte(payload[i]);
    send_byte(sum[15:8]);
    send_byte(sum[7:0]);
    frames_sent++;
  endtask

  // A full preamble followed by something other than the start byte.
  task automatic send_bad_start(input logic [7:0] b);
    repeat (PREAMBLE_LEN) send_byte(PREAMBLE_BYTE);
    send_byte(b);
  endtask

  // A header with a length above the limit, then the byte that gets discarded.
  task automatic send_oversize(input logic [15:0] len, input logic [7:0] spare);
    repeat (PREAMBLE_LEN) send_byte(PREAMBLE_BYTE);
    send_byte(START_BYTE);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    send_byte(spare);
  endtask

  // The sender stops until every predicted result has come back.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (results_due != 0);
  endtask

  // Random mix of traffic, mostly well-formed frames so that the parser gets
  // through every state, with reads spread in so the queue both fills and
  // empties.
  task automatic random_traffic(input int quota);
    int         first;
    int         pick;
    logic [7:0] b;
    first = requests_sent;
    while (requests_sent - first < quota) begin
      pick = $urandom_range(99);
      if (pick < 22) begin
        send_request(OP_READ, 8'($urandom_range(255)));
      end else if (pick < 70) begin
        send_frame(random_payload(pick_length()), 16'h0000);
      end else if (pick < 76) begin
        send_frame(random_payload(pick_length()), 16'($urandom_range(1, 16'hFFFF)));
      end else if (pick < 82) begin
        repeat ($urandom_range(0, PREAMBLE_LEN - 1)) send_byte(PREAMBLE_BYTE);
        send_byte(non_preamble());
      end else if (pick < 87) begin
        b = 8'($urandom_range(255));
        if (b == START_BYTE || $urandom_range(1) == 0) b = PREAMBLE_BYTE;
        send_bad_start(b);
      end else if (pick < 92) begin
        send_oversize(16'($urandom_range(DEF_MAX_DATA_BYTES + 1, 16'hFFFF)),
                      8'($urandom_range(255)));
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    byte_q_t full_payload;
    int      idle_plan [4];
    int      stall_plan [4];

    idle_plan  = '{0, 50, 0, 21};
    stall_plan = '{0, 0, 50, 21};

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, with no idling on either side.
    send_request(OP_READ, 8'hFF);           // read while the queue is empty
    send_byte(8'h00);                       // bad bytes while hunting, both extremes
    send_byte(8'hFF);
    repeat (3) send_byte(PREAMBLE_BYTE);    // preamble broken part way
    send_byte(8'h00);
    send_frame(random_payload(0), 16'h0000); // zero length straight to checksum
    send_request(OP_READ, 8'h00);           // zero-length message reads as empty

    send_bad_start(PREAMBLE_BYTE);          // an eighth 0xAA where the start belongs
    send_oversize(16'hFFFF, START_BYTE);    // length taken as unsigned
    send_frame(random_payload(1), 16'hFFFF); // checksum mismatch

    // Fill the queue, led by the largest frame with the smallest and largest
    // byte values inside it. One slot stays spare, so the last frame finds
    // the queue full.
    full_payload = random_payload(DEF_MAX_DATA_BYTES);
    full_payload[0] = 8'h00;
    full_payload[DEF_MAX_DATA_BYTES - 1] = 8'hFF;
    send_frame(full_payload, 16'h0000);
    repeat (DEF_QUEUE_SLOTS - 1) send_frame(random_payload($urandom_range(0, 1)), 16'h0000);
    repeat (DEF_QUEUE_SLOTS) send_request(OP_READ, 8'($urandom_range(255)));
    hold_until_drained();

    // Random part, one flow-control setting per phase, each ending with the
    // sender paused until the block has answered everything.
    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_plan[p];
      stall_pct = stall_plan[p];
      random_traffic(PHASE_ITEMS);
      hold_until_drained();
    end

    repeat (END_TAIL) @(negedge clk);

    $display("Run covered %0d requests: %0d frames, %0d reads, in %0d cycles.",
             requests_sent, frames_sent, reads_sent, cycle_count);
    $display("Traffic went through a directed part and four flow-control phases.");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
